/* design/tptu_pkg.sv */
// ---------------------------------------------------------------------------
// tptu_pkg
// Shared constants and types for the page table translator.
// ---------------------------------------------------------------------------
package tptu_pkg;

   localparam int ADDR_W     = 16;  // logical address width
   localparam int PHYS_W     = 15;  // physical address width
   localparam int PAGE_OUT_W = 8;   // width of the page numbers reported

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* design/tptu_ram.sv */
// ---------------------------------------------------------------------------
// tptu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tptu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/tptu_queue.sv */
// ---------------------------------------------------------------------------
// tptu_queue
// Two-entry queue between the address front end and the translation engine.
// ---------------------------------------------------------------------------
module tptu_queue #(
   parameter int WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      head_data,
   output tptu_pkg::q_status_type status
);

   logic [WIDTH-1:0] slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/tptu_front.sv */
// ---------------------------------------------------------------------------
// tptu_front
// Request intake: splits the logical address into page number and offset.
// ---------------------------------------------------------------------------
module tptu_front #(
   parameter int PAGE_COUNT  = 256,
   parameter int OFFSET_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          init_done,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tptu_pkg::ADDR_W-1:0]   req_logical_addr,
   input  tptu_pkg::q_status_type        q_status,
   output logic                          push,
   output logic [$clog2(PAGE_COUNT)+OFFSET_BITS-1:0] push_data
);

   localparam int PAGE_W    = $clog2(PAGE_COUNT);
   localparam bit PAGE_POW2 = (PAGE_COUNT & (PAGE_COUNT - 1)) == 0;

   if (PAGE_POW2) begin : g_mask
      logic [tptu_pkg::ADDR_W-1:0] raw_page;

      assign raw_page  = req_logical_addr >> OFFSET_BITS;
      assign req_ready = init_done && !q_status.full;
      assign push      = req_valid && req_ready;
      assign push_data = {raw_page[PAGE_W-1:0], req_logical_addr[OFFSET_BITS-1:0]};
   end else begin : g_reduce
      // page number reduced by a reciprocal multiply: the quotient estimate is
      // registered, then one multiply-subtract and one conditional subtract
      localparam int RAW_W   = tptu_pkg::ADDR_W;
      localparam int RECIP_W = RAW_W + 1;
      localparam int PROD_W  = RAW_W + RECIP_W;
      localparam int SHIFT   = RAW_W + PAGE_W;
      localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / PAGE_COUNT);

      logic               busy_ff, busy_in;
      logic               calc_ff, calc_in;
      logic [RAW_W-1:0]   raw_ff, raw_in;
      logic [RAW_W-1:0]   quot_ff, quot_in;
      logic [OFFSET_BITS-1:0] off_ff, off_in;
      logic [PROD_W-1:0]  prod;
      logic [RAW_W-1:0]   resid;
      logic               take;

      assign req_ready = init_done && !busy_ff;
      assign take      = req_valid && req_ready;
      assign push      = busy_ff && !calc_ff && !q_status.full;
      assign prod      = PROD_W'(raw_ff) * PROD_W'(RECIP);
      assign push_data = {resid[PAGE_W-1:0], off_ff};

      // estimate is low by at most one, so one correction step suffices
      always_comb begin
         resid = raw_ff - RAW_W'(quot_ff * RAW_W'(PAGE_COUNT));
         if (resid >= RAW_W'(PAGE_COUNT)) begin
            resid = resid - RAW_W'(PAGE_COUNT);
         end
      end

      always_comb begin
         busy_in = busy_ff;
         calc_in = calc_ff;
         raw_in  = raw_ff;
         quot_in = quot_ff;
         off_in  = off_ff;
         if (take) begin
            busy_in = 1'b1;
            calc_in = 1'b1;
            raw_in  = req_logical_addr >> OFFSET_BITS;
            off_in  = req_logical_addr[OFFSET_BITS-1:0];
         end else if (busy_ff && calc_ff) begin
            calc_in = 1'b0;
            quot_in = RAW_W'(prod >> SHIFT);
         end else if (push) begin
            busy_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            busy_ff <= 1'b0;
            calc_ff <= 1'b0;
         end else begin
            busy_ff <= busy_in;
            calc_ff <= calc_in;
         end
      end

      always_ff @(posedge clock) begin
         raw_ff  <= raw_in;
         quot_ff <= quot_in;
         off_ff  <= off_in;
      end
   end

endmodule

/* design/tptu_back.sv */
// ---------------------------------------------------------------------------
// tptu_back
// Translation engine: tlb search, page table walk, frame allocation and
// fifo eviction, tlb refill and the result register.
// ---------------------------------------------------------------------------
module tptu_back #(
   parameter int PAGE_COUNT  = 256,
   parameter int OFFSET_BITS = 8,
   parameter int TLB_ENTRIES = 16,
   parameter int FRAME_COUNT = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   output logic                              init_done,
   input  tptu_pkg::q_status_type            q_status,
   input  logic [$clog2(PAGE_COUNT)+OFFSET_BITS-1:0] head_data,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tptu_pkg::PHYS_W-1:0]       rsp_phys_addr,
   output logic                              rsp_tlb_hit,
   output logic                              rsp_page_fault,
   output logic [tptu_pkg::PAGE_OUT_W-1:0]   rsp_load_page,
   output logic                              rsp_evicted_valid,
   output logic [tptu_pkg::PAGE_OUT_W-1:0]   rsp_evicted_page
);

   localparam int PAGE_W  = $clog2(PAGE_COUNT);
   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam int NF_W    = $clog2(FRAME_COUNT + 1);
   localparam int TLB_W   = TLB_ENTRIES > 1 ? $clog2(TLB_ENTRIES) : 1;
   localparam int FILL_W  = $clog2(TLB_ENTRIES + 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;
   localparam logic [1:0] ST_EVICT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [PAGE_W-1:0]      clr_ff, clr_in;
   logic [NF_W-1:0]        next_free_ff, next_free_in;
   logic [FRAME_W-1:0]     victim_ff, victim_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [TLB_W-1:0]       oldest_ff, oldest_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [PAGE_W-1:0]      page_ff, page_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic                   hit_ff, hit_in;
   logic [PAGE_W-1:0]      ev_page_ff, ev_page_in;
   logic [PAGE_W-1:0]      tag_ff [TLB_ENTRIES];

   logic [tptu_pkg::PHYS_W-1:0]     phys_ff, phys_in;
   logic                            out_hit_ff, out_hit_in;
   logic                            fault_ff, fault_in;
   logic [tptu_pkg::PAGE_OUT_W-1:0] load_ff, load_in;
   logic                            evv_ff, evv_in;
   logic [tptu_pkg::PAGE_OUT_W-1:0] evp_ff, evp_in;

   logic [PAGE_W-1:0]      head_page;
   logic                   look_hit;
   logic [TLB_W-1:0]       look_idx;

   logic                   pt_we;
   logic [PAGE_W-1:0]      pt_waddr;
   logic [FRAME_W:0]       pt_wdata;
   logic [FRAME_W:0]       pt_rd;
   logic                   tlb_we;
   logic [TLB_W-1:0]       tlb_slot;
   logic [FRAME_W-1:0]     tlb_rd;
   logic                   own_we;
   logic [PAGE_W-1:0]      own_rd;

   logic                   fault;
   logic                   evict;
   logic [FRAME_W-1:0]     frame;
   logic                   out_free;

   assign init_done = (state_ff != ST_CLEAR);
   assign head_page = head_data[PAGE_W+OFFSET_BITS-1:OFFSET_BITS];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && !q_status.empty && out_free;

   // tags are unique, so at most one slot matches
   always_comb begin
      look_hit = 1'b0;
      look_idx = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if ((FILL_W'(i) < fill_ff) && (tag_ff[i] == head_page)) begin
            look_hit = 1'b1;
            look_idx = look_idx | TLB_W'(i);
         end
      end
   end

   always_comb begin
      fault = 1'b0;
      evict = 1'b0;
      if (hit_ff) begin
         frame = tlb_rd;
      end else if (pt_rd[FRAME_W]) begin
         frame = pt_rd[FRAME_W-1:0];
      end else begin
         fault = 1'b1;
         if (next_free_ff < NF_W'(FRAME_COUNT)) begin
            frame = next_free_ff[FRAME_W-1:0];
         end else begin
            evict = 1'b1;
            frame = victim_ff;
         end
      end
   end

   assign tlb_slot = (fill_ff < FILL_W'(TLB_ENTRIES)) ? fill_ff[TLB_W-1:0] : oldest_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      next_free_in = next_free_ff;
      victim_in    = victim_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      page_in      = page_ff;
      off_in       = off_ff;
      hit_in       = hit_ff;
      ev_page_in   = ev_page_ff;
      phys_in      = phys_ff;
      out_hit_in   = out_hit_ff;
      fault_in     = fault_ff;
      load_in      = load_ff;
      evv_in       = evv_ff;
      evp_in       = evp_ff;
      pt_we        = 1'b0;
      pt_waddr     = page_ff;
      pt_wdata     = '0;
      tlb_we       = 1'b0;
      own_we       = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            pt_we    = 1'b1;
            pt_waddr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == PAGE_W'(PAGE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               page_in  = head_page;
               off_in   = head_data[OFFSET_BITS-1:0];
               hit_in   = look_hit;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (fault) begin
               pt_we    = 1'b1;
               pt_wdata = {1'b1, frame};
               own_we   = 1'b1;
               if (evict) begin
                  victim_in = (victim_ff == FRAME_W'(FRAME_COUNT - 1)) ?
                              '0 : victim_ff + 1'b1;
               end else begin
                  next_free_in = next_free_ff + 1'b1;
               end
            end
            if (!hit_ff) begin
               tlb_we = 1'b1;
               if (fill_ff < FILL_W'(TLB_ENTRIES)) begin
                  fill_in = fill_ff + 1'b1;
               end else begin
                  oldest_in = (oldest_ff == TLB_W'(TLB_ENTRIES - 1)) ?
                              '0 : oldest_ff + 1'b1;
               end
            end
            rsp_valid_in = 1'b1;
            phys_in      = tptu_pkg::PHYS_W'({frame, off_ff});
            out_hit_in   = hit_ff;
            fault_in     = fault;
            load_in      = fault ? tptu_pkg::PAGE_OUT_W'(page_ff) : '0;
            evv_in       = evict;
            evp_in       = evict ? tptu_pkg::PAGE_OUT_W'(own_rd) : '0;
            ev_page_in   = own_rd;
            state_in     = evict ? ST_EVICT : ST_IDLE;
         end
         ST_EVICT: begin
            // drop the mapping of the page that lost its frame
            pt_we    = 1'b1;
            pt_waddr = ev_page_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= '0;
         victim_ff    <= '0;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
         victim_ff    <= victim_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      off_ff     <= off_in;
      hit_ff     <= hit_in;
      ev_page_ff <= ev_page_in;
      phys_ff    <= phys_in;
      out_hit_ff <= out_hit_in;
      fault_ff   <= fault_in;
      load_ff    <= load_in;
      evv_ff     <= evv_in;
      evp_ff     <= evp_in;
      if (tlb_we) begin
         tag_ff[tlb_slot] <= page_ff;
      end
   end

   // page table entry: valid bit over frame number
   tptu_ram #(.WIDTH(FRAME_W + 1), .DEPTH(PAGE_COUNT)) u_page_table (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (pt_wdata),
      .rd_en   (pop),
      .rd_addr (head_page),
      .rd_data (pt_rd)
   );

   tptu_ram #(.WIDTH(FRAME_W), .DEPTH(TLB_ENTRIES)) u_tlb_frame (
      .clock   (clock),
      .wr_en   (tlb_we),
      .wr_addr (tlb_slot),
      .wr_data (frame),
      .rd_en   (pop),
      .rd_addr (look_idx),
      .rd_data (tlb_rd)
   );

   // owner of the next victim frame is always read ahead
   tptu_ram #(.WIDTH(PAGE_W), .DEPTH(FRAME_COUNT)) u_frame_owner (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (frame),
      .wr_data (page_ff),
      .rd_en   (1'b1),
      .rd_addr (victim_ff),
      .rd_data (own_rd)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_phys_addr     = phys_ff;
   assign rsp_tlb_hit       = out_hit_ff;
   assign rsp_page_fault    = fault_ff;
   assign rsp_load_page     = load_ff;
   assign rsp_evicted_valid = evv_ff;
   assign rsp_evicted_page  = evp_ff;

endmodule

/* design/tlb_page_table_translator_unit.sv */
// ---------------------------------------------------------------------------
// tlb_page_table_translator_unit
// Logical to physical address translation through a fifo-replaced tlb and a
// demand-paged page table with fifo frame eviction.
// ---------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req       in         req_valid/req_ready   req_logical_addr
//  rsp       out        rsp_valid/rsp_ready   physical address, hit, fault,
//                                             load page, evicted page
//
//  the engine takes a request (queue pop with tlb compare and table reads),
//  then resolves it, adding a page table write when a fault evicts a frame,
//  and pops the next one only after that; the registered page table read
//  and its one write port make these separate steps
//  with a non power of two PAGE_COUNT the intake holds one request at once
//  (accept, reciprocal multiply, residue), overlapped with the engine
//  after reset a pass clearing every page table entry holds req_ready low
//  a two-entry queue and the result register let either side stall alone
// ---------------------------------------------------------------------------
module tlb_page_table_translator_unit #(
   parameter int PAGE_COUNT  = 256,
   parameter int OFFSET_BITS = 8,
   parameter int TLB_ENTRIES = 16,
   parameter int FRAME_COUNT = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tptu_pkg::ADDR_W-1:0]     req_logical_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tptu_pkg::PHYS_W-1:0]     rsp_phys_addr,
   output logic                            rsp_tlb_hit,
   output logic                            rsp_page_fault,
   output logic [tptu_pkg::PAGE_OUT_W-1:0] rsp_load_page,
   output logic                            rsp_evicted_valid,
   output logic [tptu_pkg::PAGE_OUT_W-1:0] rsp_evicted_page
);

   localparam int QW = $clog2(PAGE_COUNT) + OFFSET_BITS;

   tptu_pkg::q_status_type q_status;
   logic                   init_done;
   logic                   push;
   logic                   pop;
   logic [QW-1:0]          push_data;
   logic [QW-1:0]          head_data;

   tptu_front #(.PAGE_COUNT(PAGE_COUNT), .OFFSET_BITS(OFFSET_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .init_done        (init_done),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_logical_addr (req_logical_addr),
      .q_status         (q_status),
      .push             (push),
      .push_data        (push_data)
   );

   tptu_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (q_status)
   );

   tptu_back #(
      .PAGE_COUNT  (PAGE_COUNT),
      .OFFSET_BITS (OFFSET_BITS),
      .TLB_ENTRIES (TLB_ENTRIES),
      .FRAME_COUNT (FRAME_COUNT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .init_done         (init_done),
      .q_status          (q_status),
      .head_data         (head_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_phys_addr     (rsp_phys_addr),
      .rsp_tlb_hit       (rsp_tlb_hit),
      .rsp_page_fault    (rsp_page_fault),
      .rsp_load_page     (rsp_load_page),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page)
   );

endmodule

/* design/tptu_checker.sv */
// ---------------------------------------------------------------------------
// tptu_checker
// Port-level checks on the translator, bound to the top level.
// ---------------------------------------------------------------------------
module tptu_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [tptu_pkg::ADDR_W-1:0]     req_logical_addr,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tptu_pkg::PHYS_W-1:0]     rsp_phys_addr,
   input logic                            rsp_tlb_hit,
   input logic                            rsp_page_fault,
   input logic [tptu_pkg::PAGE_OUT_W-1:0] rsp_load_page,
   input logic                            rsp_evicted_valid,
   input logic [tptu_pkg::PAGE_OUT_W-1:0] rsp_evicted_page
);

   // clearing pass keeps intake closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during page table clear");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phys_addr)
         && $stable(rsp_page_fault) && $stable(rsp_evicted_page))
      else $error("stalled response changed");

   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("tlb hit reported together with page fault");

   a_evict_needs_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> rsp_page_fault)
      else $error("eviction without page fault");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_page_fault |-> rsp_load_page == '0 && rsp_evicted_page == '0)
      else $error("fault fields set without a fault");

endmodule

bind tlb_page_table_translator_unit tptu_checker u_tptu_checker (.*);

/* test/tlb_page_table_translator_unit_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tlb_page_table_translator_unit_tb
// Drives logical addresses into the translator and checks every translation
// against a predictor with its own tlb, page table and frame owner state.
// Runs directed corner addresses, then locality-shaped random traffic under
// several idle and stall mixes, a long receiver hold-off and full drains.
// ---------------------------------------------------------------------------
module tlb_page_table_translator_unit_tb;

   localparam int PAGES       = 256;
   localparam int OFFSET_W    = 8;
   localparam int TLB_SLOTS   = 16;
   localparam int FRAMES      = 128;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [tptu_pkg::PHYS_W-1:0]     phys_addr;
      logic                            tlb_hit;
      logic                            page_fault;
      logic [tptu_pkg::PAGE_OUT_W-1:0] load_page;
      logic                            evicted_valid;
      logic [tptu_pkg::PAGE_OUT_W-1:0] evicted_page;
   } translation_type;

   class xlate_scoreboard;
      int              frame_of_page[PAGES];
      bit              page_resident[PAGES];
      int              page_in_frame[FRAMES];
      int              frames_handed;
      int              next_victim;
      int              tlb_tag[TLB_SLOTS];
      int              tlb_frame_no[TLB_SLOTS];
      int              tlb_used;
      int              tlb_next_replace;
      translation_type expected_translations[$];
      int              errors;
      int              responses_seen;

      task report_mismatch(string msg);
         $display("%0t ns: mismatch on response %0d: %s", $time, responses_seen, msg);
         errors++;
      endtask

      // predicts the translation of one accepted request and updates the state
      function void note_request(logic [tptu_pkg::ADDR_W-1:0] addr);
         int              page;
         int              offset;
         int              frame;
         int              slot;
         int              old_page;
         int              i;
         bit              hit;
         translation_type want;
         page   = (addr >> OFFSET_W) % PAGES;
         offset = addr & ((1 << OFFSET_W) - 1);
         frame  = 0;
         hit    = 1'b0;
         want   = '0;
         for (i = 0; i < tlb_used; i++) begin
            if (!hit && tlb_tag[i] == page) begin
               hit   = 1'b1;
               frame = tlb_frame_no[i];
            end
         end
         if (!hit) begin
            if (page_resident[page]) begin
               frame = frame_of_page[page];
            end else begin
               want.page_fault = 1'b1;
               want.load_page  = tptu_pkg::PAGE_OUT_W'(page);
               if (frames_handed < FRAMES) begin
                  frame = frames_handed;
                  frames_handed++;
               end else begin
                  // frames exhausted: reuse in fifo order, drop the old owner's mapping
                  frame                 = next_victim;
                  old_page              = page_in_frame[frame];
                  want.evicted_valid    = 1'b1;
                  want.evicted_page     = tptu_pkg::PAGE_OUT_W'(old_page);
                  page_resident[old_page] = 1'b0;
                  next_victim           = (frame + 1) % FRAMES;
               end
               frame_of_page[page]  = frame;
               page_resident[page]  = 1'b1;
               page_in_frame[frame] = page;
            end
            if (tlb_used < TLB_SLOTS) begin
               slot = tlb_used;
               tlb_used++;
            end else begin
               slot             = tlb_next_replace;
               tlb_next_replace = (slot + 1) % TLB_SLOTS;
            end
            tlb_tag[slot]      = page;
            tlb_frame_no[slot] = frame;
         end
         // stale tlb entries of evicted pages still hit with their old frame
         want.tlb_hit   = hit;
         want.phys_addr = tptu_pkg::PHYS_W'((frame << OFFSET_W) + offset);
         expected_translations.push_back(want);
      endfunction

      task check_response(translation_type got);
         translation_type want;
         if (expected_translations.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected, phys %0h",
                                      got.phys_addr));
         end else begin
            want = expected_translations.pop_front();
            if (got.phys_addr !== want.phys_addr)
               report_mismatch($sformatf("phys_addr got %0h want %0h",
                                         got.phys_addr, want.phys_addr));
            if (got.tlb_hit !== want.tlb_hit)
               report_mismatch($sformatf("tlb_hit got %0b want %0b",
                                         got.tlb_hit, want.tlb_hit));
            if (got.page_fault !== want.page_fault)
               report_mismatch($sformatf("page_fault got %0b want %0b",
                                         got.page_fault, want.page_fault));
            if (got.load_page !== want.load_page)
               report_mismatch($sformatf("load_page got %0h want %0h",
                                         got.load_page, want.load_page));
            if (got.evicted_valid !== want.evicted_valid)
               report_mismatch($sformatf("evicted_valid got %0b want %0b",
                                         got.evicted_valid, want.evicted_valid));
            if (got.evicted_page !== want.evicted_page)
               report_mismatch($sformatf("evicted_page got %0h want %0h",
                                         got.evicted_page, want.evicted_page));
         end
         responses_seen++;
      endtask

      function int outstanding();
         return expected_translations.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [tptu_pkg::ADDR_W-1:0]     req_logical_addr;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [tptu_pkg::PHYS_W-1:0]     rsp_phys_addr;
   logic                            rsp_tlb_hit;
   logic                            rsp_page_fault;
   logic [tptu_pkg::PAGE_OUT_W-1:0] rsp_load_page;
   logic                            rsp_evicted_valid;
   logic [tptu_pkg::PAGE_OUT_W-1:0] rsp_evicted_page;

   xlate_scoreboard sb = new();
   int              cycle_count = 0;
   int              sender_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              rsp_hold_cycles = 0;
   int              recent_pages[$];

   tlb_page_table_translator_unit #(
      .PAGE_COUNT (PAGES),
      .OFFSET_BITS(OFFSET_W),
      .TLB_ENTRIES(TLB_SLOTS),
      .FRAME_COUNT(FRAMES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_logical_addr (req_logical_addr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_phys_addr    (rsp_phys_addr),
      .rsp_tlb_hit      (rsp_tlb_hit),
      .rsp_page_fault   (rsp_page_fault),
      .rsp_load_page    (rsp_load_page),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_page (rsp_evicted_page)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tlb_page_table_translator_unit_tb: done, errors");
      $finish;
   end

   // handshakes are sampled at the rising edge, before the block updates
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_logical_addr);
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_phys_addr, rsp_tlb_hit, rsp_page_fault,
                               rsp_load_page, rsp_evicted_valid, rsp_evicted_page});
      end
   end

   // receiver: a requested hold-off first, otherwise random stalls
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // mostly hot pages (tlb hits), some warm ones (table hits), rest anywhere
   function automatic logic [tptu_pkg::ADDR_W-1:0] pick_address();
      int roll;
      int span;
      int page;
      roll = $urandom_range(99);
      span = recent_pages.size();
      if (roll < 45 && span > 0)
         page = recent_pages[span - 1 - $urandom_range((span < 12 ? span : 12) - 1)];
      else if (roll < 70 && span > 0)
         page = recent_pages[$urandom_range(span - 1)];
      else
         page = $urandom_range(PAGES - 1);
      recent_pages.push_back(page);
      if (recent_pages.size() > 96)
         void'(recent_pages.pop_front());
      return tptu_pkg::ADDR_W'((page << OFFSET_W) | $urandom_range((1 << OFFSET_W) - 1));
   endfunction

   task send_request(logic [tptu_pkg::ADDR_W-1:0] addr);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_logical_addr <= addr;
      do @(posedge clock); while (!req_ready);
   endtask

   // sender stays quiet until every expected translation has come back
   task wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task run_traffic(int count, int send_idle, int stall);
      int i;
      sender_idle_pct = send_idle;
      rsp_stall_pct   = stall;
      for (i = 0; i < count; i++)
         send_request(pick_address());
      wait_for_drain();
   endtask

   logic [tptu_pkg::ADDR_W-1:0] directed_addrs[] = '{
      16'h0000, 16'h0000, 16'hFFFF, 16'hFF00, 16'h00FF, 16'h8001, 16'h7FFE,
      16'h5555, 16'hAAAA, 16'h0101, 16'h0202, 16'h0303, 16'h0404, 16'h0505,
      16'h0606, 16'h0707, 16'h0808, 16'h0909, 16'h0A0A, 16'h0B0B, 16'h0042,
      16'hFF80
   };

   initial begin
      int i;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_logical_addr = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners, hits after faults, tlb fill past capacity, table hit after tlb loss
      for (i = 0; i < directed_addrs.size(); i++)
         send_request(directed_addrs[i]);
      wait_for_drain();

      run_traffic(400, 0, 0);
      run_traffic(400, 79, 0);
      run_traffic(400, 0, 79);
      run_traffic(400, 36, 36);

      // long receiver hold-off while the sender keeps pushing
      rsp_hold_cycles = 150;
      run_traffic(40, 0, 0);

      run_traffic(240, 20, 20);

      repeat (20) @(posedge clock);
      if (sb.outstanding() != 0)
         sb.report_mismatch($sformatf("%0d translations never arrived", sb.outstanding()));
      if (sb.errors == 0)
         $display("tlb_page_table_translator_unit_tb: done, clean");
      else
         $display("tlb_page_table_translator_unit_tb: done, errors");
      $finish;
   end

endmodule
